// ===== rtl/acpi_dsdt_s5_extractor_top_defines.svh =====
// Assertion macros for the DSDT S5 extractor checker.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ACPI_DSDT_S5_EXTRACTOR_TOP_DEFINES_SVH
`define ACPI_DSDT_S5_EXTRACTOR_TOP_DEFINES_SVH

// Checked only while out of reset.
`define S5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define S5_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/dsdt_s5_pkg.sv =====
// Shared types, constants and helpers for the DSDT S5 extractor.
// Used by the top level and its checker; depends on nothing.
package dsdt_s5_pkg;

  // Fixed table layout.
  localparam int unsigned HEADER_BYTES = 36;
  localparam logic [7:0]  OP_NAME      = 8'h08;
  localparam logic [7:0]  OP_PACKAGE   = 8'h12;
  localparam logic [7:0]  PFX_BYTE     = 8'h0A;
  localparam logic [7:0]  PKG_LEN_MASK = 8'hC0;
  localparam logic [7:0]  ROOT_CHAR    = 8'h5C;
  localparam logic [31:0] NAME_S5      = 32'h5F53355F;
  localparam logic [15:0] SLP_EN_BIT   = 16'h2000;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NO_S5     = 2'd2,
    ST_PARSE_ERR = 2'd3
  } status_e;

  // Parser phases, one-hot.
  typedef enum logic [9:0] {
    PH_SEARCH  = 10'b00_0000_0001,
    PH_OPCODE  = 10'b00_0000_0010,
    PH_PKGLEAD = 10'b00_0000_0100,
    PH_SKIP    = 10'b00_0000_1000,
    PH_A_PRE   = 10'b00_0001_0000,
    PH_A_VAL   = 10'b00_0010_0000,
    PH_B_PRE   = 10'b00_0100_0000,
    PH_B_VAL   = 10'b00_1000_0000,
    PH_DONE    = 10'b01_0000_0000,
    PH_ERROR   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] slp_typa_word;
    logic [15:0] slp_typb_word;
  } out_beat_t;

  // Signature character expected at header byte 0 to 3.
  function automatic logic [7:0] sig_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h44;
      2'd1:    c = 8'h53;
      2'd2:    c = 8'h44;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  // PM1 control word: low six bits of the sleep type in bits 15:10, which
  // also overlaps the enable bit 13; the enable bit is always set.
  function automatic logic [15:0] make_word(input logic [7:0] t);
    return {t[5:0], 10'b0} | SLP_EN_BIT;
  endfunction

endpackage

// ===== rtl/acpi_dsdt_s5_extractor_top.sv =====
// DSDT S5 sleep-type extractor, top level.
// Depends on dsdt_s5_pkg.
//
// Usage:
//   The input channel carries one table byte per beat, starting at the DSDT
//   header, with last set on the final byte. The output channel carries one
//   result beat per table, produced only for the byte marked last: a status
//   and the two PM1 control words for the S5 state (zero unless status is ok).
//   Datapath: a beat is accepted into the input register and processed from
//   there; the result for its last byte is written into the result register,
//   which drives the output. Throughput is one byte per cycle while no final
//   byte waits, set by the single input and result registers.
//   If the receiver stalls, the pending result holds; further non-final bytes
//   keep flowing, and only a final byte waits in the input register until
//   the result register frees up.
//   Reset clears both registers' valid flags and returns the parser to its
//   search state with an empty checksum, ready for a new table. After each
//   result the parser returns to that same state on its own.
module acpi_dsdt_s5_extractor_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dsdt_s5_pkg::in_beat_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dsdt_s5_pkg::out_beat_t out_data_o
);
  import dsdt_s5_pkg::*;

  // Input register.
  logic      in_valid_q, in_valid_d;
  in_beat_t  in_q;
  logic      fire;

  // Parser state.
  logic [31:0] idx_q, idx_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic        sig_ok_q, sig_ok_d;
  logic [39:0] recent_q, recent_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  skip_q, skip_d;
  logic [7:0]  type_a_q, type_a_d;
  logic [7:0]  type_b_q, type_b_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  // Per-byte decode.
  logic [7:0]  b;
  logic        in_header;
  logic        in_len_field;
  logic        below_len;
  logic        in_body;
  logic        name_hit;
  logic [32:0] count;
  logic        table_ok;
  status_e     status;

  // A final byte may only move on when the result register can take it.
  assign fire       = in_valid_q && (!in_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Byte position tests.
  assign b            = in_q.data_byte;
  assign in_header    = (idx_q[31:3] == 29'd0);
  assign in_len_field = in_header && idx_q[2];
  assign below_len    = (idx_q < len_q);
  assign in_body      = !in_header && below_len;
  assign name_hit     = ({recent_q[23:0], b} == NAME_S5) &&
                        (idx_q >= 32'(HEADER_BYTES + 3));

  // Header, checksum and parser update for one byte.
  always_comb begin
    sig_ok_d = sig_ok_q;
    len_d    = len_q;
    sum_d    = sum_q;
    phase_d  = phase_q;
    skip_d   = skip_q;
    type_a_d = type_a_q;
    type_b_d = type_b_q;
    recent_d = {recent_q[31:0], b};
    idx_d    = (&idx_q) ? idx_q : idx_q + 32'd1;

    if (in_header && !idx_q[2] && (b != sig_char(idx_q[1:0]))) begin
      sig_ok_d = 1'b0;
    end

    if (in_len_field) begin
      case (idx_q[1:0])
        2'd0:    len_d[7:0]   = b;
        2'd1:    len_d[15:8]  = b;
        2'd2:    len_d[23:16] = b;
        default: len_d[31:24] = b;
      endcase
    end

    if (in_header || below_len) begin
      sum_d = sum_q + b;
    end

    if (in_body) begin
      unique case (phase_q)
        PH_SEARCH: begin
          if (name_hit) begin
            if ((recent_q[31:24] == OP_NAME) ||
                ((recent_q[39:32] == OP_NAME) && (recent_q[31:24] == ROOT_CHAR))) begin
              phase_d = PH_OPCODE;
            end else begin
              phase_d = PH_ERROR;
            end
          end
        end
        PH_OPCODE: begin
          phase_d = (b == OP_PACKAGE) ? PH_PKGLEAD : PH_ERROR;
        end
        PH_PKGLEAD: begin
          skip_d  = {1'b0, b[7:6] & PKG_LEN_MASK[7:6]} + 3'd1;
          phase_d = PH_SKIP;
        end
        PH_SKIP: begin
          if (skip_q != 3'd0) begin
            skip_d = skip_q - 3'd1;
          end
          if (skip_d == 3'd0) begin
            phase_d = PH_A_PRE;
          end
        end
        PH_A_PRE: begin
          if (b == PFX_BYTE) begin
            phase_d = PH_A_VAL;
          end else begin
            type_a_d = b;
            phase_d  = PH_B_PRE;
          end
        end
        PH_A_VAL: begin
          type_a_d = b;
          phase_d  = PH_B_PRE;
        end
        PH_B_PRE: begin
          if (b == PFX_BYTE) begin
            phase_d = PH_B_VAL;
          end else begin
            type_b_d = b;
            phase_d  = PH_DONE;
          end
        end
        PH_B_VAL: begin
          type_b_d = b;
          phase_d  = PH_DONE;
        end
        PH_DONE, PH_ERROR: begin
          phase_d = phase_q;
        end
        default: begin
          phase_d = PH_ERROR;
        end
      endcase
    end
  end

  // Final verdict, taken from the state after this byte.
  assign count    = {1'b0, idx_q} + 33'd1;
  assign table_ok = sig_ok_d && (idx_q >= 32'd7) &&
                    (len_d >= 32'(HEADER_BYTES)) &&
                    (count >= {1'b0, len_d}) && (sum_d == 8'd0);

  always_comb begin
    if (!table_ok) begin
      status = ST_INVALID;
    end else if (phase_d == PH_SEARCH) begin
      status = ST_NO_S5;
    end else if (phase_d == PH_DONE) begin
      status = ST_OK;
    end else begin
      status = ST_PARSE_ERR;
    end
  end

  always_comb begin
    out_d.status        = status;
    out_d.slp_typa_word = (status == ST_OK) ? make_word(type_a_d) : 16'd0;
    out_d.slp_typb_word = (status == ST_OK) ? make_word(type_b_d) : 16'd0;
  end

  // State registers: a final byte returns everything to the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      sig_ok_q <= 1'b1;
      recent_q <= '0;
      phase_q  <= PH_SEARCH;
      skip_q   <= '0;
      type_a_q <= '0;
      type_b_q <= '0;
    end else if (fire) begin
      if (in_q.last) begin
        idx_q    <= '0;
        len_q    <= '0;
        sum_q    <= '0;
        sig_ok_q <= 1'b1;
        recent_q <= '0;
        phase_q  <= PH_SEARCH;
        skip_q   <= '0;
        type_a_q <= '0;
        type_b_q <= '0;
      end else begin
        idx_q    <= idx_d;
        len_q    <= len_d;
        sum_q    <= sum_d;
        sig_ok_q <= sig_ok_d;
        recent_q <= recent_d;
        phase_q  <= phase_d;
        skip_q   <= skip_d;
        type_a_q <= type_a_d;
        type_b_q <= type_b_d;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire && in_q.last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_q.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/dsdt_s5_chk.sv =====
// Port-level checker for the DSDT S5 extractor, with its bind statement.
// Depends on dsdt_s5_pkg and acpi_dsdt_s5_extractor_top_defines.svh.
`include "acpi_dsdt_s5_extractor_top_defines.svh"

module dsdt_s5_chk (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input dsdt_s5_pkg::in_beat_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input dsdt_s5_pkg::out_beat_t out_data_o
);
  import dsdt_s5_pkg::*;

  // Classification of the offered result beat.
  logic ok_beat;
  logic err_beat;
  logic words_zero;
  logic words_form;

  assign ok_beat    = out_valid_o && (out_data_o.status == ST_OK);
  assign err_beat   = out_valid_o && (out_data_o.status != ST_OK);
  assign words_zero = (out_data_o.slp_typa_word == 16'd0) &&
                      (out_data_o.slp_typb_word == 16'd0);
  assign words_form = out_data_o.slp_typa_word[13] && out_data_o.slp_typb_word[13] &&
                      (out_data_o.slp_typa_word[9:0] == 10'd0) &&
                      (out_data_o.slp_typb_word[9:0] == 10'd0);

  // A result beat stays offered until it is taken.
  `S5_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // No result is offered in the cycle after reset is seen low.
  `S5_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result offered during reset")

  // A failed table carries zero words.
  `S5_ASSERT(a_err_zero, err_beat |-> words_zero, "non-zero words on failed table")

  // A good result has the enable bit set and the low ten bits clear.
  `S5_ASSERT(a_ok_form, ok_beat |-> words_form, "malformed PM1 control word")

endmodule

bind acpi_dsdt_s5_extractor_top dsdt_s5_chk u_dsdt_s5_chk (.*);
